// ----- hdl/integer_to_radix_ascii_core_assert.svh -----
// Assertion macros for the integer_to_radix_ascii_core checker.
// No dependencies; included by the checker file only.
`ifndef INTEGER_TO_RADIX_ASCII_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ITORA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Same-cycle condition checked outside reset.
`define ITORA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked on every clock edge, reset included.
`define ITORA_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/itora_pkg.sv -----
// Shared constants, types and a helper function of the radix-to-ASCII block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itora_pkg;

   localparam int VALUE_BITS_DEFAULT = 63;
   localparam int RADIX_W = 5;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   localparam logic [CHAR_W-1:0] DIGIT_GLYPHS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };

   typedef struct packed {
      logic load;   // start on a new dividend
      logic cont;   // divide the held quotient again
   } div_cmd_type;

   typedef struct packed {
      logic               done;    // one-cycle pulse, digit ready
      logic               zero;    // quotient is zero
      logic [DIGIT_W-1:0] rem;     // remainder digit
   } div_status_type;

   function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] e;
      e = r;
      if (r < RADIX_MIN) e = RADIX_MIN;
      if (r > RADIX_MAX) e = RADIX_MAX;
      return e;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/itora_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module itora_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 63
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hdl/itora_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, small radix divisor.
// Depends on itora_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itora_div #(
   parameter int VALUE_BITS = itora_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire itora_pkg::div_cmd_type          cmd,
   input  wire logic [VALUE_BITS-1:0]           dividend,
   input  wire logic [itora_pkg::RADIX_W-1:0]   radix,
   output itora_pkg::div_status_type            status
);

   localparam int BW = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0]         q_ff;
   logic [itora_pkg::DIGIT_W-1:0] rem_ff;
   logic [BW-1:0]                 bit_cnt_ff;
   logic                          running_ff;
   logic                          done_ff;

   logic [itora_pkg::RADIX_W-1:0] trial;
   logic [itora_pkg::RADIX_W-1:0] diff;
   logic                          ge;
   logic [itora_pkg::DIGIT_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, q_ff[VALUE_BITS-1]};
      ge     = (trial >= radix);
      diff   = trial - radix;
      rem_in = ge ? diff[itora_pkg::DIGIT_W-1:0] : trial[itora_pkg::DIGIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.load || cmd.cont) begin
            running_ff <= 1'b1;
            bit_cnt_ff <= '0;
         end else if (running_ff) begin
            bit_cnt_ff <= bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BW'(VALUE_BITS - 1)) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end
         end
      end
   end

   // payload: quotient shifts left, new bit enters at the bottom
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_ff   <= dividend;
         rem_ff <= '0;
      end else if (cmd.cont) begin
         rem_ff <= '0;
      end else if (running_ff) begin
         q_ff   <= {q_ff[VALUE_BITS-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign status.done = done_ff;
   assign status.zero = (q_ff == '0);
   assign status.rem  = rem_ff;

endmodule

`default_nettype wire

// ----- hdl/integer_to_radix_ascii_core.sv -----
// Top level of the integer-to-radix ASCII converter.
// Depends on itora_pkg, itora_div and itora_ram.
//
// Usage:
//  - req channel: one unsigned VALUE_BITS-bit integer per transfer (req_valid/req_stall).
//  - rsp channel: one ASCII digit per transfer, most significant first;
//    rsp_last marks the least significant digit. Zero gives the single digit '0'.
//  - csr port: csr_write_enable writes csr_write_data into the radix register.
//    Radix below 2 acts as 2, above 16 acts as 16. Write it only while idle.
// Timing:
//  - Each digit takes one pass through the bit-serial divider, which
//    shifts one dividend bit per cycle through a 4-bit remainder.
//  - After the last division the digits are read back from the reversal RAM,
//    each by a registered read, then an output register load.
//  - The first digit is valid only after all divisions; the next item is
//    taken once the last digit has been loaded into the output register.
//  - req_stall is low only while idle; the last digit may still wait in the
//    output register while the next item is taken.
// Reset: synchronous, active high; radix returns to 10 and all channels go idle.
// Stall: a stalled rsp holds its digit; readback pauses until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_ascii_core #(
   parameter int VALUE_BITS = itora_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [itora_pkg::RADIX_W-1:0]  csr_write_data,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [VALUE_BITS-1:0]          req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [itora_pkg::CHAR_W-1:0]   rsp_digit_char,
   output logic                                rsp_last
);

   localparam int AW = $clog2(VALUE_BITS);
   localparam int CW = $clog2(VALUE_BITS + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_READ = 4'b0100,
      ST_LOAD = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [itora_pkg::RADIX_W-1:0] radix_ff;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [itora_pkg::CHAR_W-1:0]  char_ff;
   logic                          last_ff;

   itora_pkg::div_cmd_type        div_cmd;
   itora_pkg::div_status_type     div_status;

   logic                          req_xfer;
   logic                          out_free;
   logic                          out_load;
   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_rd_addr;
   logic [itora_pkg::DIGIT_W-1:0] ram_rd_data;
   logic [CW-1:0]                 cnt_minus1;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Radix register; effective clamp applied at the divider input
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itora_pkg::RADIX_RESET;
      end else if (csr_write_enable) begin
         radix_ff <= csr_write_data;
      end
   end

   itora_div #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (div_cmd),
      .dividend(req_value),
      .radix   (itora_pkg::effective_radix(radix_ff)),
      .status  (div_status)
   );

   // Digits land least significant first; readback walks the addresses down
   assign cnt_minus1  = cnt_ff - CW'(1);
   assign ram_rd_addr = cnt_minus1[AW-1:0];

   itora_ram #(
      .WIDTH(itora_pkg::DIGIT_W),
      .DEPTH(VALUE_BITS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(cnt_ff[AW-1:0]),
      .wr_data(div_status.rem),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      div_cmd.load = 1'b0;
      div_cmd.cont = 1'b0;
      ram_wr_en    = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               div_cmd.load = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            // store each digit; divide again until the quotient runs out
            if (div_status.done) begin
               ram_wr_en = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
               if (div_status.zero) begin
                  state_in = ST_READ;
               end else begin
                  div_cmd.cont = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // hold the read address until the output register frees up
            if (out_free) begin
               out_load = 1'b1;
               cnt_in   = cnt_minus1;
               state_in = (cnt_ff == CW'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload: advance only on a load
   always_ff @(posedge clock) begin
      if (out_load) begin
         char_ff <= itora_pkg::DIGIT_GLYPHS[ram_rd_data];
         last_ff <= (cnt_ff == CW'(1));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ----- hdl/integer_to_radix_ascii_core_checker.sv -----
// Port-level assertion checker for integer_to_radix_ascii_core, with its bind.
// Depends on itora_pkg and integer_to_radix_ascii_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_radix_ascii_core_assert.svh"

module integer_to_radix_ascii_core_checker #(
   parameter int VALUE_BITS = itora_pkg::VALUE_BITS_DEFAULT
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          csr_write_enable,
   input wire logic [itora_pkg::RADIX_W-1:0] csr_write_data,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [VALUE_BITS-1:0]         req_value,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [itora_pkg::CHAR_W-1:0]  rsp_digit_char,
   input wire logic                          rsp_last
);

   // a stalled digit holds
   `ITORA_ASSERT_IMP(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last))

   // the block is busy right after taking an item
   `ITORA_ASSERT_IMP(a_busy_after_req, req_valid && !req_stall, req_stall)

   // only upper-case hex digit codes leave the block
   `ITORA_ASSERT_NOW(a_char_range, rsp_valid, (rsp_digit_char >= 7'h30 && rsp_digit_char <= 7'h39) || (rsp_digit_char >= 7'h41 && rsp_digit_char <= 7'h46))

   // reset leaves both channels idle
   `ITORA_ASSERT_RST(a_reset_idle, reset, !rsp_valid && !req_stall)

endmodule

bind integer_to_radix_ascii_core integer_to_radix_ascii_core_checker #(
   .VALUE_BITS(VALUE_BITS)
) u_checker (.*);

`default_nettype wire

// ----- tb/itora_digit_checker.sv -----
`timescale 1ns / 1ps
// Digit checker for integer_to_radix_ascii_core: follows the radix register, predicts
// the digit string of every accepted value and compares each rsp transfer in order.
// Depends on itora_pkg.

module itora_digit_checker #(
   parameter int VALUE_BITS = itora_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [itora_pkg::RADIX_W-1:0] csr_write_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [VALUE_BITS-1:0]         req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [itora_pkg::CHAR_W-1:0]  rsp_digit_char,
   input  logic                          rsp_last,
   output int                            fail_count,
   output int                            outstanding
);

   localparam logic [itora_pkg::CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
   localparam logic [itora_pkg::CHAR_W-1:0] CHAR_ALPHA = 7'h41;  // 'A'

   typedef struct packed {
      logic [itora_pkg::CHAR_W-1:0] digit_char;
      logic                         last;
   } digit_t;

   digit_t                        pending_digits[$];
   logic [itora_pkg::RADIX_W-1:0] radix_reg = itora_pkg::RADIX_RESET;

   function automatic logic [itora_pkg::RADIX_W-1:0] clamp_radix(
      input logic [itora_pkg::RADIX_W-1:0] r);
      if (r < 5'd2) return 5'd2;
      if (r > 5'd16) return 5'd16;
      return r;
   endfunction

   function automatic logic [itora_pkg::CHAR_W-1:0] glyph_of(input logic [3:0] d);
      if (d < 4'd10) return CHAR_ZERO + d;
      return CHAR_ALPHA + (d - 4'd10);
   endfunction

   // Divide down to zero, stacking digits so the most significant comes out first.
   task automatic queue_digits(input logic [VALUE_BITS-1:0] v,
                               input logic [itora_pkg::RADIX_W-1:0] r);
      logic [VALUE_BITS-1:0]         rest;
      logic [itora_pkg::RADIX_W-1:0] base;
      digit_t                        stack[$];
      digit_t                        item;
      base = clamp_radix(r);
      rest = v;
      if (rest == '0) begin
         item.digit_char = CHAR_ZERO;
         item.last = 1'b1;
         stack.push_front(item);
      end
      while (rest != '0) begin
         item.digit_char = glyph_of(4'(rest % base));
         item.last = (stack.size() == 0);
         stack.push_front(item);
         rest = rest / base;
      end
      foreach (stack[i]) pending_digits.push_back(stack[i]);
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      digit_t want;
      if (reset) begin
         radix_reg = itora_pkg::RADIX_RESET;
         pending_digits.delete();
         fail_count = 0;
      end else begin
         // Pop before pushing: a digit leaving now belongs to an older value.
         if (rsp_valid && !rsp_stall) begin
            if (pending_digits.size() == 0) begin
               report_mismatch($sformatf("unexpected digit 0x%02h last %0b",
                                         rsp_digit_char, rsp_last));
            end else begin
               want = pending_digits.pop_front();
               if (rsp_digit_char != want.digit_char)
                  report_mismatch($sformatf("digit_char 0x%02h, wanted 0x%02h",
                                            rsp_digit_char, want.digit_char));
               if (rsp_last != want.last)
                  report_mismatch($sformatf("last %0b, wanted %0b", rsp_last, want.last));
            end
         end
         if (csr_write_enable) radix_reg = csr_write_data;
         if (req_valid && !req_stall) queue_digits(req_value, radix_reg);
      end
      outstanding <= pending_digits.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for integer_to_radix_ascii_core; prediction and comparison
// live in itora_digit_checker. Depends on itora_pkg, itora_digit_checker and the block.

module tb_top;

   localparam int VALUE_BITS = itora_pkg::VALUE_BITS_DEFAULT;
   // A 63-digit value stays in the divider through all its divisions before its first
   // digit leaves; allow that several times over, plus long rsp stall runs.
   localparam int WATCHDOG_LIMIT = 40000;
   // The last digit may sit in the output register; let the block settle.
   localparam int SETTLE_CYCLES  = 16;
   localparam int SEGMENTS       = 4;
   localparam int SEGMENT_ITEMS  = 10;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic [itora_pkg::RADIX_W-1:0] csr_write_data = '0;
   logic                          req_valid = 1'b0;
   logic [VALUE_BITS-1:0]         req_value = '0;
   logic                          rsp_stall = 1'b0;
   wire                           req_stall;
   wire                           rsp_valid;
   wire  [itora_pkg::CHAR_W-1:0]  rsp_digit_char;
   wire                           rsp_last;

   int                            src_idle_pct  = 28;
   int                            sink_idle_pct = 81;
   int                            fail_count;
   int                            outstanding;
   int                            quiet_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   integer_to_radix_ascii_core #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_char   (rsp_digit_char),
      .rsp_last         (rsp_last)
   );

   itora_digit_checker #(.VALUE_BITS(VALUE_BITS)) u_digit_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_char   (rsp_digit_char),
      .rsp_last         (rsp_last),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // Receiver backpressure: a fresh coin each cycle at the current idle rate.
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < sink_idle_pct);

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[integer_to_radix_ascii_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one value and return at the edge where it transfers. Valid stays high
   // into the next call unless that call idles first, so it never drops and
   // rises in the same step.
   task automatic send_value(input logic [VALUE_BITS-1:0] v);
      if ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold off until every predicted digit has come out.
   // The count is registered, so look only from the next edge on.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Radix writes happen only once the block is drained and idle.
   task automatic write_radix(input logic [itora_pkg::RADIX_W-1:0] r);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= r;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Mix of zero, all ones, powers of the radix and one below them (where the
   // digit count steps), and random values of random bit length.
   function automatic logic [VALUE_BITS-1:0] random_value(
      input logic [itora_pkg::RADIX_W-1:0] r);
      logic [63:0]                   power;
      logic [itora_pkg::RADIX_W-1:0] base;
      int                            width;
      int                            k;
      case ($urandom_range(9))
         0: return '0;
         1: return VALUE_MAX;
         2, 3: begin
            base = (r < 5'd2) ? 5'd2 : (r > 5'd16) ? 5'd16 : r;
            power = 64'd1;
            for (k = $urandom_range(1, 62); k > 0; k--)
               if (power <= VALUE_MAX / base) power = power * base;
            if ($urandom_range(1) == 0) return power[VALUE_BITS-1:0];
            return power[VALUE_BITS-1:0] - 1'b1;
         end
         default: begin
            width = $urandom_range(1, VALUE_BITS);
            return VALUE_BITS'({$urandom, $urandom} & ((64'd1 << width) - 64'd1));
         end
      endcase
   endfunction

   initial begin
      int                            phase;
      int                            seg;
      int                            n;
      logic [itora_pkg::RADIX_W-1:0] radix_pick;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset radix first, then the radix extremes and the clamped codes.
      send_value('0);
      send_value(63'd1);
      send_value(63'd9);
      send_value(63'd10);
      send_value(VALUE_MAX);
      send_value(63'd1234567890123456789);
      write_radix(5'd2);
      send_value('0);
      send_value(63'd1);
      send_value(VALUE_MAX);                        // longest string, 63 digits
      send_value(63'h4000_0000_0000_0000);
      write_radix(5'd16);
      send_value(63'h0123_4567_89AB_CDEF);          // every glyph but 0 once
      send_value(63'h7EDC_BA98_7654_3210);
      send_value(VALUE_MAX);
      write_radix(5'd0);                            // below two acts as two
      send_value(63'd5);
      write_radix(5'd1);
      send_value(63'd6);
      write_radix(5'd17);                           // above sixteen acts as sixteen
      send_value(63'd255);
      write_radix(5'd31);
      send_value(63'hAB_CDEF);
      write_radix(5'd3);
      send_value(VALUE_MAX);
      write_radix(5'd7);
      send_value(63'd48);

      // Random: three idling profiles, several radix settings in each.
      for (phase = 0; phase < 3; phase++) begin
         drain_results();
         case (phase)
            0: begin src_idle_pct = 28; sink_idle_pct = 81; end
            1: begin src_idle_pct = 81; sink_idle_pct = 28; end
            default: begin src_idle_pct = 0; sink_idle_pct = 0; end
         endcase
         for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0)
               radix_pick = (phase == 0) ? 5'd2 : (phase == 1) ? 5'd16 : 5'd31;
            else if ($urandom_range(1) == 0)
               radix_pick = 5'($urandom_range(2, 16));
            else
               radix_pick = 5'($urandom_range(0, 31));
            write_radix(radix_pick);
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
               send_value(random_value(radix_pick));
               // Now and then hold the sender until the block has emptied.
               if ($urandom_range(19) == 0) drain_results();
            end
         end
      end

      drain_results();
      if (fail_count == 0 && outstanding == 0) begin
         $display("[integer_to_radix_ascii_core] OK");
      end else begin
         $display("[integer_to_radix_ascii_core] ERROR");
      end
      $finish;
   end

endmodule
